FILE: src/erfs_pkg.sv
// Shared types and constants for the earliest-free room scheduler.
// No dependencies; imported by the controller, datapath and top level.
package erfs_pkg;

	localparam int NUM_ROOMS   = 16;
	localparam int IDX_W       = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
	localparam int NR_W        = $clog2(NUM_ROOMS + 1);
	localparam int CFG_W       = 5;
	localparam int TIME_IN_W   = 32;
	localparam int TIME_W      = 48;
	localparam int CNT_W       = 24;
	localparam int ROOM_OUT_W  = 4;
	localparam int IN_DATA_W   = 64;
	localparam int OUT_DATA_W  = 64;
	localparam logic [CFG_W-1:0] ROOMS_RESET = CFG_W'(16);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_SUM,
		ST_FINISH
	} erfs_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
		logic sum;
		logic idx_clr;
		logic out_load;
		logic clear;
	} erfs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;
		logic idx_last;
		logic last;
		logic in_bad;
		logic in_last;
		logic out_busy;
	} erfs_sts_t;

endpackage

FILE: src/erfs_ctrl.sv
// Sequencer for the room scheduler: scan, commit, summary, hand-off.
// Depends on erfs_pkg for the state enum and the command/status structs.
module erfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  erfs_pkg::erfs_sts_t sts,
	output erfs_pkg::erfs_cmd_t cmd
);
	import erfs_pkg::*;

	erfs_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!sts.in_bad) state_nxt = ST_SCAN;
					else if (sts.in_last) state_nxt = ST_SUM;
					else state_nxt = ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (sts.hit || sts.idx_last) state_nxt = ST_COMMIT;
			end
			ST_COMMIT: begin
				state_nxt = sts.last ? ST_SUM : ST_FINISH;
			end
			ST_SUM: begin
				if (sts.idx_last) state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (!sts.out_busy) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit  = 1'b1;
				cmd.idx_clr = 1'b1;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
			end
			ST_FINISH: begin
				cmd.out_load = !sts.out_busy;
				cmd.clear    = !sts.out_busy && sts.last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: src/erfs_dp.sv
// Datapath: room store, scan index, min/best trackers, result register.
// Depends on erfs_pkg; driven by erfs_ctrl through erfs_cmd_t.
module erfs_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [erfs_pkg::CFG_W-1:0]         cfg_wr_data,
	input  logic [erfs_pkg::IN_DATA_W-1:0]     in_data,
	input  logic                               in_last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [erfs_pkg::OUT_DATA_W-1:0]    out_data,
	output logic                               out_last,
	input  erfs_pkg::erfs_cmd_t                cmd,
	output erfs_pkg::erfs_sts_t                sts
);
	import erfs_pkg::*;

	localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
	localparam logic [TIME_W-1:0] TIME_MAX  = '1;

	logic [CFG_W-1:0]     rooms_q;
	logic [NR_W-1:0]      n_act;

	logic [TIME_W-1:0]    free_mem [NUM_ROOMS];
	logic [CNT_W-1:0]     cnt_mem  [NUM_ROOMS];
	logic [NUM_ROOMS-1:0] ent_vld_q;

	logic [TIME_IN_W-1:0] start_q, end_q, dur_q;
	logic                 last_q;
	logic [IDX_W-1:0]     idx_q, sel_q, best_q;
	logic [CNT_W-1:0]     sel_cnt_q, best_cnt_q;
	logic [TIME_W-1:0]    min_free_q;
	logic                 found_q;

	logic [ROOM_OUT_W-1:0] res_room_q;
	logic [TIME_W-1:0]     res_fin_q;
	logic                  res_dly_q, res_bad_q;
	logic                  out_vld_q, out_last_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [TIME_IN_W-1:0] in_start, in_end;
	logic [TIME_W-1:0]    rd_free, fin;
	logic [CNT_W-1:0]     rd_cnt, new_cnt;
	logic [TIME_W:0]      dly_sum;
	logic                 hit;

	assign in_start = in_data[TIME_IN_W-1:0];
	assign in_end   = in_data[2*TIME_IN_W-1:TIME_IN_W];

	// rooms_in_use clamped to 1..NUM_ROOMS
	always_comb begin
		if (rooms_q == '0) n_act = NR_W'(1);
		else if (32'(rooms_q) > NUM_ROOMS) n_act = NR_W'(NUM_ROOMS);
		else n_act = NR_W'(rooms_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rooms_q <= ROOMS_RESET;
		end else if (cfg_wr_en) begin
			rooms_q <= cfg_wr_data;
		end
	end

	// an entry that was never written since the last clear reads as zero
	assign rd_free = ent_vld_q[idx_q] ? free_mem[idx_q] : '0;
	assign rd_cnt  = ent_vld_q[idx_q] ? cnt_mem[idx_q]  : '0;
	assign hit     = rd_free <= TIME_W'(start_q);

	assign dly_sum = {1'b0, min_free_q} + (TIME_W + 1)'(dur_q);
	assign fin     = found_q ? TIME_W'(end_q) :
	                 (dly_sum[TIME_W] ? TIME_MAX : dly_sum[TIME_W-1:0]);
	assign new_cnt = (sel_cnt_q == COUNT_MAX) ? COUNT_MAX : sel_cnt_q + CNT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			free_mem[sel_q] <= fin;
			cnt_mem[sel_q]  <= new_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (cmd.clear) begin
			ent_vld_q <= '0;
		end else if (cmd.commit) begin
			ent_vld_q[sel_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load || cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.scan || cmd.sum) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q    <= in_start;
			end_q      <= in_end;
			dur_q      <= in_end - in_start;
			last_q     <= in_last;
			found_q    <= 1'b0;
			res_room_q <= '0;
			res_fin_q  <= '0;
			res_dly_q  <= 1'b0;
			res_bad_q  <= in_end <= in_start;
		end
		// first room seeds the minimum; a free room ends the scan
		if (cmd.scan && (hit || idx_q == '0 || rd_free < min_free_q)) begin
			sel_q      <= idx_q;
			sel_cnt_q  <= rd_cnt;
			min_free_q <= rd_free;
			found_q    <= hit;
		end
		if (cmd.commit) begin
			res_room_q <= ROOM_OUT_W'(sel_q);
			res_fin_q  <= fin;
			res_dly_q  <= !found_q;
		end
		if (cmd.sum && (idx_q == '0 || rd_cnt > best_cnt_q)) begin
			best_q     <= idx_q;
			best_cnt_q <= rd_cnt;
		end
		if (cmd.out_load) begin
			out_data_q <= OUT_DATA_W'({
				(last_q ? ROOM_OUT_W'(best_q) : ROOM_OUT_W'(0)),
				res_bad_q, res_dly_q, res_fin_q, res_room_q});
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	always_comb begin
		sts          = '0;
		sts.hit      = hit;
		sts.idx_last = (NR_W'(idx_q) + NR_W'(1)) == n_act;
		sts.last     = last_q;
		sts.in_bad   = in_end <= in_start;
		sts.in_last  = in_last;
		sts.out_busy = out_vld_q && !out_ready;
	end

endmodule

FILE: src/earliest_free_room_scheduler_core.sv
// Top level of the earliest-free room scheduler: stream ports, config write port.
// Depends on erfs_pkg, erfs_ctrl and erfs_dp.
//
// One booking word is taken at a time; s_axis_tready is high only while the
// sequencer is idle. A booking walks the rooms in use one per cycle through a
// single read port of the room store, stopping at the first room free by its
// start time. It visits k rooms (1..n, n being the clamped rooms_in_use), then
// goes through the commit and hand-off states. A booking marked tlast adds a
// pass over the n booking counts to find the most-booked room, then clears
// the store. A bad interval skips the room walk and the commit, adding the
// count pass if last. Results sit in an output register, so the next booking
// is taken while a result waits; a further result stalls only in the hand-off
// state until the output register drains.
module earliest_free_room_scheduler_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [erfs_pkg::CFG_W-1:0]         cfg_wr_data,    // rooms_in_use
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] booking start, [63:32] booking end
	input  logic [erfs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  logic                               s_axis_tlast,   // last_booking
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [3:0] room, [51:4] finish_time, [52] was_delayed, [53] bad_interval,
	// [57:54] most_booked_room, [63:58] zero
	output logic [erfs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tlast    // summary_valid
);
	import erfs_pkg::*;

	erfs_cmd_t cmd;
	erfs_sts_t sts;

	erfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	erfs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_last    (m_axis_tlast),
		.cmd         (cmd),
		.sts         (sts)
	);

`ifndef SYNTHESIS
	// one booking at a time: no word right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("booking accepted while previous one in flight");

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
		else $error("result register overwritten");

	// a rejected interval is never booked
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[53] |->
		m_axis_tdata[51:0] == '0 && !m_axis_tdata[52])
		else $error("bad interval carries a booking");

	// the store is only cleared on the summary hand-off
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> m_axis_tvalid && m_axis_tlast)
		else $error("store cleared without summary");
`endif

endmodule

FILE: verif/earliest_free_room_scheduler_core_tb.sv
// Self-checking bench for earliest_free_room_scheduler_core: directed table, one-room
// run of chained delays, then random booking sets under random handshake stalls.
// Depends on erfs_pkg and the scheduler RTL.
module earliest_free_room_scheduler_core_tb;
	import erfs_pkg::*;

	typedef struct packed {
		logic [ROOM_OUT_W-1:0] room;
		logic [TIME_W-1:0]     finish;
		logic                  delayed;
		logic                  bad;
		logic [ROOM_OUT_W-1:0] best;
		logic                  summary;
	} booking_result_t;

	typedef enum logic {ROW_BOOK, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t       kind;
		logic [31:0]     st;     // rooms_in_use value on a config row
		logic [31:0]     en;
		logic            last;
		logic            typed;
		booking_result_t want;
	} plan_row_t;

	localparam booking_result_t NONE     = '0;
	localparam booking_result_t BAD_ONLY = '{4'd0, 48'd0, 1'b0, 1'b1, 4'd0, 1'b0};
	localparam int LONG_RUN   = 24;
	localparam int RAND_ITEMS = 500;
	localparam int CALM_AFTER = 430;
	localparam int DRAIN_CYC  = 48;

	localparam plan_row_t PLAN [0:26] = '{
		'{ROW_BOOK, 32'd0, 32'd10, 1'b0, 1'b1, '{4'd0, 48'd10, 1'b0, 1'b0, 4'd0, 1'b0}},
		'{ROW_BOOK, 32'd5, 32'd5, 1'b0, 1'b1, BAD_ONLY},
		'{ROW_BOOK, 32'd7, 32'd3, 1'b0, 1'b1, BAD_ONLY},
		'{ROW_BOOK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, BAD_ONLY},
		'{ROW_BOOK, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1, BAD_ONLY},
		'{ROW_BOOK, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1,
			'{4'd1, 48'hFFFF_FFFF, 1'b0, 1'b0, 4'd0, 1'b0}},
		'{ROW_BOOK, 32'd10, 32'd20, 1'b0, 1'b1, '{4'd0, 48'd20, 1'b0, 1'b0, 4'd0, 1'b0}},
		// bad interval on the last word still summarizes and clears
		'{ROW_BOOK, 32'd3, 32'd3, 1'b1, 1'b1, '{4'd0, 48'd0, 1'b0, 1'b1, 4'd0, 1'b1}},
		'{ROW_BOOK, 32'd0, 32'd1, 1'b1, 1'b1, '{4'd0, 48'd1, 1'b0, 1'b0, 4'd0, 1'b1}},
		'{ROW_CFG, 32'd1, 32'd0, 1'b0, 1'b0, NONE},
		'{ROW_BOOK, 32'd0, 32'd100, 1'b0, 1'b1, '{4'd0, 48'd100, 1'b0, 1'b0, 4'd0, 1'b0}},
		'{ROW_BOOK, 32'd50, 32'd60, 1'b0, 1'b1, '{4'd0, 48'd110, 1'b1, 1'b0, 4'd0, 1'b0}},
		'{ROW_BOOK, 32'd50, 32'hFFFF_FFFF, 1'b1, 1'b0, NONE},
		// zero rooms behaves as one
		'{ROW_CFG, 32'd0, 32'd0, 1'b0, 1'b0, NONE},
		'{ROW_BOOK, 32'd0, 32'd5, 1'b0, 1'b1, '{4'd0, 48'd5, 1'b0, 1'b0, 4'd0, 1'b0}},
		'{ROW_BOOK, 32'd1, 32'd9, 1'b0, 1'b1, '{4'd0, 48'd13, 1'b1, 1'b0, 4'd0, 1'b0}},
		'{ROW_BOOK, 32'd2, 32'd4, 1'b1, 1'b0, NONE},
		'{ROW_CFG, 32'd3, 32'd0, 1'b0, 1'b0, NONE},
		'{ROW_BOOK, 32'd0, 32'd10, 1'b0, 1'b1, '{4'd0, 48'd10, 1'b0, 1'b0, 4'd0, 1'b0}},
		'{ROW_BOOK, 32'd0, 32'd10, 1'b0, 1'b1, '{4'd1, 48'd10, 1'b0, 1'b0, 4'd0, 1'b0}},
		'{ROW_BOOK, 32'd0, 32'd10, 1'b0, 1'b1, '{4'd2, 48'd10, 1'b0, 1'b0, 4'd0, 1'b0}},
		// all three busy until 10: tie goes to the lowest room
		'{ROW_BOOK, 32'd2, 32'd5, 1'b0, 1'b0, NONE},
		'{ROW_BOOK, 32'd11, 32'd12, 1'b0, 1'b0, NONE},
		'{ROW_BOOK, 32'd12, 32'd30, 1'b1, 1'b0, NONE},
		// above the room count clamps to the full set
		'{ROW_CFG, 32'd31, 32'd0, 1'b0, 1'b0, NONE},
		'{ROW_BOOK, 32'd0, 32'd4, 1'b0, 1'b0, NONE},
		'{ROW_BOOK, 32'd1, 32'd3, 1'b1, 1'b0, NONE}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_W-1:0]      cfg_wr_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	// scoreboard-side copy of the scheduler state
	logic [CFG_W-1:0]  rooms_cfg;
	logic [TIME_W-1:0] free_at [NUM_ROOMS];
	logic [CNT_W-1:0]  bk_count [NUM_ROOMS];
	booking_result_t   due_results [$];

	bit idle_on;
	int stall_left;
	int fail_count, results_seen, setting_count;
	int bookings_directed, bookings_long, bookings_random;

	earliest_free_room_scheduler_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	function automatic booking_result_t dispatch_booking(input logic [31:0] st,
			input logic [31:0] en, input logic last);
		booking_result_t r;
		int n, pick, best, i;
		bit hit;
		logic [TIME_W-1:0] lowest, dur;
		r = '0;
		n = (rooms_cfg == 0) ? 1 : (rooms_cfg > NUM_ROOMS) ? NUM_ROOMS : int'(rooms_cfg);
		if (en <= st) begin
			r.bad = 1'b1;
		end else begin
			hit = 1'b0;
			pick = 0;
			lowest = free_at[0];
			for (i = 0; i < n && !hit; i++) begin
				if (free_at[i] <= TIME_W'(st)) begin
					hit = 1'b1;
					pick = i;
				end else if (free_at[i] < lowest) begin
					lowest = free_at[i];
					pick = i;
				end
			end
			if (hit) begin
				r.finish = TIME_W'(en);
			end else begin
				dur = TIME_W'(en) - TIME_W'(st);
				r.delayed = 1'b1;
				r.finish = (free_at[pick] > {TIME_W{1'b1}} - dur) ? {TIME_W{1'b1}}
					: free_at[pick] + dur;
			end
			free_at[pick] = r.finish;
			if (bk_count[pick] != {CNT_W{1'b1}})
				bk_count[pick] = bk_count[pick] + 1'b1;
			r.room = pick[ROOM_OUT_W-1:0];
		end
		if (last) begin
			best = 0;
			for (i = 1; i < n; i++)
				if (bk_count[i] > bk_count[best])
					best = i;
			r.best = best[ROOM_OUT_W-1:0];
			r.summary = 1'b1;
			foreach (free_at[j]) begin
				free_at[j] = '0;
				bk_count[j] = '0;
			end
		end
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_booking(input logic [31:0] st, input logic [31:0] en,
			input logic last, input bit typed, input booking_result_t typed_want);
		booking_result_t model_out;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {en, st};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		model_out = dispatch_booking(st, en, last);
		due_results.push_back(typed ? typed_want : model_out);
		@(negedge clk);
	endtask

	// Only while idle: drain results, let the summary/clear pass finish, then write.
	task automatic set_rooms(input logic [CFG_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		wait (due_results.size() == 0);
		repeat (DRAIN_CYC) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		rooms_cfg = v;
		setting_count++;
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] want_v,
			input logic [TIME_W-1:0] got_v);
		if (got_v !== want_v) begin
			fail_count++;
			$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
		end
	endtask

	// sink stalls at random, in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left = $urandom_range(0, 6);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		booking_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (due_results.size() == 0) begin
				fail_count++;
				$error("result word with nothing expected: tdata 0x%0h", m_axis_tdata);
			end else begin
				want = due_results.pop_front();
				check_field("room", TIME_W'(want.room), TIME_W'(m_axis_tdata[3:0]));
				check_field("finish_time", want.finish, m_axis_tdata[51:4]);
				check_field("was_delayed", TIME_W'(want.delayed), TIME_W'(m_axis_tdata[52]));
				check_field("bad_interval", TIME_W'(want.bad), TIME_W'(m_axis_tdata[53]));
				check_field("most_booked_room", TIME_W'(want.best),
					TIME_W'(m_axis_tdata[57:54]));
				check_field("summary_valid", TIME_W'(want.summary), TIME_W'(m_axis_tlast));
			end
		end
	end

	initial begin
		#(12 * 4_000_000);
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [63:0]      cursor, end_w;
		logic [31:0]      st, en;
		logic [CFG_W-1:0] v;
		logic             last;
		int               load, plen;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		rooms_cfg     = ROOMS_RESET;
		foreach (free_at[j]) begin
			free_at[j] = '0;
			bk_count[j] = '0;
		end
		idle_on = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_CFG) begin
				set_rooms(PLAN[i].st[CFG_W-1:0]);
			end else begin
				send_booking(PLAN[i].st, PLAN[i].en, PLAN[i].last, PLAN[i].typed, PLAN[i].want);
				bookings_directed++;
			end
		end

		// one room, maximal durations: every word after the first is delayed,
		// each pushing the room's free time out by almost 2^32
		idle_on = 1'b0;
		set_rooms(CFG_W'(1));
		for (int k = 0; k < LONG_RUN; k++) begin
			send_booking(32'd0, 32'hFFFF_FFFF, k == LONG_RUN - 1, 1'b0, NONE);
			bookings_long++;
		end

		idle_on = 1'b1;
		cursor = '0;
		load = 40;
		while (bookings_random < RAND_ITEMS) begin
			case ($urandom_range(0, 5))
				0: v = CFG_W'(0);
				1: v = CFG_W'(1);
				2: v = CFG_W'(16);
				3: v = CFG_W'(31);
				default: v = CFG_W'($urandom_range(0, 31));
			endcase
			set_rooms(v);
			plen = $urandom_range(15, 50);
			for (int k = 0; k < plen && bookings_random < RAND_ITEMS; k++) begin
				if (bookings_random >= CALM_AFTER)
					idle_on = 1'b0;
				if ($urandom_range(0, 9) == 0) begin
					// noise: arbitrary words, many of them bad intervals
					st = $urandom();
					en = ($urandom_range(0, 2) == 0) ? st : $urandom();
					last = ($urandom_range(0, 7) == 0);
				end else begin
					cursor += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1000000)
						: $urandom_range(0, 8);
					if (cursor > 64'hFFFF_FFFF)
						cursor = 64'hFFFF_FFFF;
					end_w = cursor + (($urandom_range(0, 14) == 0) ? $urandom()
						: $urandom_range(1, load));
					if (end_w > 64'hFFFF_FFFF)
						end_w = 64'hFFFF_FFFF;
					st = cursor[31:0];
					en = end_w[31:0];
					last = ($urandom_range(0, 11) == 0);
					if (last) begin
						case ($urandom_range(0, 3))
							0: cursor = '0;
							1: cursor = $urandom_range(0, 1000);
							2: cursor = $urandom();
							default: cursor = 64'hFFFF_FF00;
						endcase
						load = $urandom_range(4, 150);
					end
				end
				send_booking(st, en, last, 1'b0, NONE);
				bookings_random++;
			end
		end

		s_axis_tvalid <= 1'b0;
		wait (due_results.size() == 0);
		repeat (DRAIN_CYC) @(negedge clk);
		$display("Bookings sent: %0d directed, %0d in the one-room delay chain, %0d random",
			bookings_directed, bookings_long, bookings_random);
		$display("Room-count settings applied: %0d; result words compared: %0d",
			setting_count, results_seen);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
